// ===== design/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_SHIFT = 10;
    localparam int MODE_THRESH = 4;
    localparam int SCALE_SHIFT = 14;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_KP_HOLD       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_HOLD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_RAMP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_RAMP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd6;

    localparam logic [15:0] RST_KP            = 16'h27ff;
    localparam logic [15:0] RST_KI            = 16'h0140;
    localparam logic [11:0] RST_ACCEL_STEP    = 12'd1;
    localparam logic [15:0] RST_STEP_INTERVAL = 16'd10;
    localparam logic [15:0] RST_SPEED_SCALE   = 16'h4000;

    typedef enum logic [1:0] {
        MODE_HOLD = 2'd0,
        MODE_ACC  = 2'd1,
        MODE_DEC  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        OP_TARGET,
        OP_RAMP,
        OP_CLAMP,
        OP_SCALE,
        OP_ERR,
        OP_INTEG,
        OP_KI,
        OP_SUM,
        OP_ROUND,
        OP_DRIVE
    } t_op;

    typedef enum logic {
        COND_NONE,
        COND_HOLD
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] jump;
        logic            last;
    } t_uword;

    typedef struct packed {
        logic [15:0] kp_hold;
        logic [15:0] ki_hold;
        logic [15:0] kp_ramp;
        logic [15:0] ki_ramp;
        logic [11:0] accel_step;
        logic [15:0] step_interval;
        logic [15:0] speed_scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic exec;
        t_op  op;
    } t_dp_ctrl;

    function automatic t_uword prog_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_DRIVE, cond: COND_NONE, jump: '0, last: 1'b1};
        case (pc)
            4'd0: w = '{op: OP_TARGET, cond: COND_HOLD, jump: 4'd2, last: 1'b0};
            4'd1: w = '{op: OP_RAMP,   cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd2: w = '{op: OP_CLAMP,  cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd3: w = '{op: OP_SCALE,  cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd4: w = '{op: OP_ERR,    cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd5: w = '{op: OP_INTEG,  cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd6: w = '{op: OP_KI,     cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd7: w = '{op: OP_SUM,    cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd8: w = '{op: OP_ROUND,  cond: COND_NONE, jump: '0,   last: 1'b0};
            4'd9: w = '{op: OP_DRIVE,  cond: COND_NONE, jump: '0,   last: 1'b1};
            default: w = '{op: OP_DRIVE, cond: COND_NONE, jump: '0, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/spc_datapath.sv =====
`default_nettype none

module spc_datapath #(
    parameter int SPEED_BITS = 12
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire spc_pkg::t_dp_ctrl   i_ctrl,
    input  wire [SPEED_BITS-1:0]     i_speed_command,
    input  wire [SPEED_BITS-1:0]     i_measured_speed,
    input  wire [31:0]               i_time_now,
    input  wire spc_pkg::t_cfg       i_cfg,
    output spc_pkg::t_mode           o_mode,
    output logic [15:0]              o_goal_value,
    output logic [15:0]              o_drive_value
);

    localparam int SP_W   = SPEED_BITS + 2;
    localparam int DIFF_W = SPEED_BITS + 1;
    localparam int GOAL_W = (SPEED_BITS + 3 > 18) ? SPEED_BITS + 3 : 18;
    localparam int ERR_W  = GOAL_W + 1;
    localparam int ACC_W  = spc_pkg::ACC_W;
    localparam int PROD_W = spc_pkg::PROD_W;

    localparam logic signed [GOAL_W-1:0] G_MAX = GOAL_W'(32767);
    localparam logic signed [GOAL_W-1:0] G_MIN = GOAL_W'(-32768);
    localparam logic signed [ACC_W:0]    D_MAX = (ACC_W + 1)'(32767);
    localparam logic signed [ACC_W:0]    D_MIN = (ACC_W + 1)'(-32768);
    localparam logic signed [PROD_W-1:0] SC_MASK =
        PROD_W'((64'd1 << spc_pkg::SCALE_SHIFT) - 64'd1);
    localparam logic signed [ACC_W-1:0]  GS_MASK =
        ACC_W'((64'd1 << spc_pkg::GAIN_SHIFT) - 64'd1);
    localparam logic signed [DIFF_W-1:0] THR_P = DIFF_W'(spc_pkg::MODE_THRESH);
    localparam logic signed [DIFF_W-1:0] THR_N = DIFF_W'(-spc_pkg::MODE_THRESH);

    spc_pkg::t_mode r_mode, n_mode;
    logic signed [15:0]        r_ramp_goal, n_ramp_goal;
    logic signed [31:0]        r_integ, n_integ;
    logic [31:0]               r_last, n_last;
    logic [31:0]               r_now, n_now;
    logic signed [SP_W-1:0]    r_target, n_target;
    logic signed [SP_W-1:0]    r_cur, n_cur;
    logic signed [GOAL_W-1:0]  r_goal, n_goal;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [ACC_W-1:0]   r_acc, n_acc;

    logic signed [spc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [spc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]           mul_p;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [SP_W-1:0]    in_target;
    logic signed [SP_W-1:0]    in_cur;
    logic signed [GOAL_W-1:0]  tgt_w;
    logic signed [GOAL_W-1:0]  rg_w;
    logic signed [GOAL_W-1:0]  step_w;
    logic                      due;
    logic signed [GOAL_W-1:0]  clamp_goal;
    logic                      clamp_hit;
    logic signed [15:0]        sat_goal;
    logic signed [PROD_W-1:0]  scale_rnd;
    logic signed [ERR_W-1:0]   scaled;
    logic signed [32:0]        integ_sum;
    logic signed [31:0]        integ_sat;
    logic [15:0]               kp_sel;
    logic [15:0]               ki_sel;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [ACC_W:0]     drive_sum;

    assign diff = $signed({i_speed_command[SPEED_BITS-1], i_speed_command})
                - $signed({i_measured_speed[SPEED_BITS-1], i_measured_speed});
    assign in_target = $signed({i_speed_command, 2'b00});
    assign in_cur    = $signed({i_measured_speed, 2'b00});

    assign tgt_w  = GOAL_W'(r_target);
    assign rg_w   = GOAL_W'(r_ramp_goal);
    assign step_w = $signed(GOAL_W'(i_cfg.accel_step));
    assign due    = {1'b0, r_now} > ({1'b0, r_last} + {17'd0, i_cfg.step_interval});

    always_comb begin
        clamp_goal = r_goal;
        clamp_hit  = 1'b0;
        if (r_mode == spc_pkg::MODE_ACC && r_goal > tgt_w) begin
            clamp_goal = tgt_w;
            clamp_hit  = 1'b1;
        end else if (r_mode == spc_pkg::MODE_DEC && r_goal < tgt_w) begin
            clamp_goal = tgt_w;
            clamp_hit  = 1'b1;
        end
        if (clamp_goal > G_MAX) begin
            sat_goal = 16'sh7fff;
        end else if (clamp_goal < G_MIN) begin
            sat_goal = -16'sh8000;
        end else begin
            sat_goal = 16'(clamp_goal);
        end
    end

    assign scale_rnd = r_prod + (r_prod[PROD_W-1] ? SC_MASK : '0);
    assign scaled    = ERR_W'(scale_rnd >>> spc_pkg::SCALE_SHIFT);

    assign integ_sum = 33'(r_integ) + 33'(r_err);
    always_comb begin
        if (integ_sum[32] != integ_sum[31]) begin
            integ_sat = integ_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            integ_sat = integ_sum[31:0];
        end
    end

    assign kp_sel = (r_mode == spc_pkg::MODE_HOLD) ? i_cfg.kp_hold : i_cfg.kp_ramp;
    assign ki_sel = (r_mode == spc_pkg::MODE_HOLD) ? i_cfg.ki_hold : i_cfg.ki_ramp;

    assign acc_rnd   = $signed(r_acc + (r_acc[ACC_W-1] ? GS_MASK : '0))
                       >>> spc_pkg::GAIN_SHIFT;
    assign drive_sum = (ACC_W + 1)'(r_cur) + (ACC_W + 1)'(r_acc);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            spc_pkg::OP_SCALE: begin
                mul_a = spc_pkg::MUL_A_W'(r_ramp_goal);
                mul_b = $signed({1'b0, i_cfg.speed_scale});
            end
            spc_pkg::OP_INTEG: begin
                mul_a = spc_pkg::MUL_A_W'(r_err);
                mul_b = $signed({1'b0, kp_sel});
            end
            spc_pkg::OP_KI: begin
                mul_a = r_integ;
                mul_b = $signed({1'b0, ki_sel});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        n_mode      = r_mode;
        n_ramp_goal = r_ramp_goal;
        n_integ     = r_integ;
        n_last      = r_last;
        n_now       = r_now;
        n_target    = r_target;
        n_cur       = r_cur;
        n_goal      = r_goal;
        n_prod      = r_prod;
        n_err       = r_err;
        n_acc       = r_acc;
        if (i_ctrl.load) begin
            n_now    = i_time_now;
            n_target = in_target;
            n_cur    = in_cur;
            if (diff > THR_P) begin
                n_mode = spc_pkg::MODE_ACC;
            end else if (diff < THR_N) begin
                n_mode = spc_pkg::MODE_DEC;
            end else begin
                n_mode = spc_pkg::MODE_HOLD;
            end
        end else if (i_ctrl.exec) begin
            case (i_ctrl.op)
                spc_pkg::OP_TARGET: n_goal = tgt_w;
                spc_pkg::OP_RAMP: begin
                    n_goal = rg_w;
                    if (due) begin
                        n_last = r_now;
                        n_goal = (r_mode == spc_pkg::MODE_ACC) ? rg_w + step_w
                                                               : rg_w - step_w;
                    end
                end
                spc_pkg::OP_CLAMP: begin
                    if (r_mode != spc_pkg::MODE_HOLD && r_now < r_last) begin
                        n_last = r_now;
                    end
                    if (clamp_hit) begin
                        n_mode = spc_pkg::MODE_HOLD;
                    end
                    n_ramp_goal = sat_goal;
                end
                spc_pkg::OP_SCALE: n_prod = mul_p;
                spc_pkg::OP_ERR:   n_err  = scaled - ERR_W'(r_cur);
                spc_pkg::OP_INTEG: begin
                    n_integ = integ_sat;
                    n_prod  = mul_p;
                end
                spc_pkg::OP_KI: begin
                    n_acc  = ACC_W'(r_prod);
                    n_prod = mul_p;
                end
                spc_pkg::OP_SUM:   n_acc = r_acc + ACC_W'(r_prod);
                spc_pkg::OP_ROUND: n_acc = acc_rnd;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= spc_pkg::MODE_HOLD;
            r_ramp_goal <= '0;
            r_integ     <= '0;
            r_last      <= '0;
        end else begin
            r_mode      <= n_mode;
            r_ramp_goal <= n_ramp_goal;
            r_integ     <= n_integ;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_target <= n_target;
        r_cur    <= n_cur;
        r_goal   <= n_goal;
        r_prod   <= n_prod;
        r_err    <= n_err;
        r_acc    <= n_acc;
    end

    always_comb begin
        if (drive_sum > D_MAX) begin
            o_drive_value = 16'h7fff;
        end else if (drive_sum < D_MIN) begin
            o_drive_value = 16'h8000;
        end else begin
            o_drive_value = drive_sum[15:0];
        end
    end

    assign o_mode       = r_mode;
    assign o_goal_value = r_ramp_goal;

endmodule

`default_nettype wire

// ===== design/speed_ramp_pi_controller.sv =====
// Speed ramp with PI drive correction, one beat in and one beat out per
// control period.
// Input channel (i_in_valid / o_in_ready): speed command, measured speed and
// the tick counter value. Output channel (o_out_valid / i_out_ready): drive
// value, mode and ramped goal.
// The user must write gains, ramp step, step interval and goal scale through
// the plain register port (i_cfg_wr_en, i_cfg_idx, i_cfg_data) only while
// idle; the block does not enforce this. Unknown indexes are dropped.
// Each beat runs a microcode program that steps a single shared 32x17
// multiplier; in hold mode it jumps over the ramp step. No new beat is
// taken while the program runs: the next beat is accepted the cycle after
// the result is registered, so beats do not overlap in the program.
// The result sits in an output register, and the next beat is accepted
// while it waits; if the receiver still stalls when the following result is
// due, the program holds at its last step.
// Synchronous active-low reset restores the register defaults and clears the
// goal, integrator and step time; no result is pending after reset.
`default_nettype none

module speed_ramp_pi_controller #(
    parameter int SPEED_BITS = 12
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [SPEED_BITS-1:0]              i_speed_command,
    input  wire [SPEED_BITS-1:0]              i_measured_speed,
    input  wire [31:0]                        i_time_now,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [15:0]                       o_drive_value,
    output logic [1:0]                        o_speed_mode,
    output logic [15:0]                       o_goal_value,
    input  wire                               i_cfg_wr_en,
    input  wire [spc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [spc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    spc_pkg::t_cfg            r_cfg, n_cfg;
    logic                     r_busy, n_busy;
    logic [spc_pkg::PC_W-1:0] r_pc, n_pc;
    logic                     r_out_valid, n_out_valid;
    logic [15:0]              r_drive;
    logic [15:0]              r_goal;
    spc_pkg::t_mode           r_mode_out;

    spc_pkg::t_uword   uw;
    spc_pkg::t_dp_ctrl dp_ctrl;
    spc_pkg::t_mode    dp_mode;
    logic [15:0]       dp_goal;
    logic [15:0]       dp_drive;
    logic              accept;
    logic              stall;
    logic              exec;
    logic              finish;

    assign uw       = spc_pkg::prog_rom(r_pc);
    assign accept   = i_in_valid && !r_busy;
    assign stall    = uw.last && r_out_valid && !i_out_ready;
    assign exec     = r_busy && !stall;
    assign finish   = exec && uw.last;

    assign dp_ctrl.load = accept;
    assign dp_ctrl.exec = exec;
    assign dp_ctrl.op   = uw.op;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                spc_pkg::REG_KP_HOLD:       n_cfg.kp_hold       = i_cfg_data;
                spc_pkg::REG_KI_HOLD:       n_cfg.ki_hold       = i_cfg_data;
                spc_pkg::REG_KP_RAMP:       n_cfg.kp_ramp       = i_cfg_data;
                spc_pkg::REG_KI_RAMP:       n_cfg.ki_ramp       = i_cfg_data;
                spc_pkg::REG_ACCEL_STEP:    n_cfg.accel_step    = i_cfg_data[11:0];
                spc_pkg::REG_STEP_INTERVAL: n_cfg.step_interval = i_cfg_data;
                spc_pkg::REG_SPEED_SCALE:   n_cfg.speed_scale   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end else if (exec) begin
            if (uw.last) begin
                n_busy = 1'b0;
            end else if (uw.cond == spc_pkg::COND_HOLD && dp_mode == spc_pkg::MODE_HOLD) begin
                n_pc = uw.jump;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_hold       <= spc_pkg::RST_KP;
            r_cfg.ki_hold       <= spc_pkg::RST_KI;
            r_cfg.kp_ramp       <= spc_pkg::RST_KP;
            r_cfg.ki_ramp       <= spc_pkg::RST_KI;
            r_cfg.accel_step    <= spc_pkg::RST_ACCEL_STEP;
            r_cfg.step_interval <= spc_pkg::RST_STEP_INTERVAL;
            r_cfg.speed_scale   <= spc_pkg::RST_SPEED_SCALE;
            r_busy              <= 1'b0;
            r_pc                <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_drive    <= dp_drive;
            r_goal     <= dp_goal;
            r_mode_out <= dp_mode;
        end
    end

    spc_datapath #(
        .SPEED_BITS (SPEED_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (dp_ctrl),
        .i_speed_command  (i_speed_command),
        .i_measured_speed (i_measured_speed),
        .i_time_now       (i_time_now),
        .i_cfg            (r_cfg),
        .o_mode           (dp_mode),
        .o_goal_value     (dp_goal),
        .o_drive_value    (dp_drive)
    );

    assign o_in_ready    = !r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;
    assign o_speed_mode  = r_mode_out;
    assign o_goal_value  = r_goal;

endmodule

`default_nettype wire
